// ===== rtl/core/sspc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sspc_pkg;

  // Default number of parameter bytes held per packet
  localparam int MAX_PARAMS_DEF = 16;

  // Header bytes and CRC polynomial
  localparam logic [7:0]  HDR_SYNC   = 8'hFF;
  localparam logic [7:0]  HDR_LAST   = 8'hFD;
  localparam logic [15:0] CRC_POLY   = 16'h8005;
  localparam logic [7:0]  ID_RST_VAL = 8'h01;

  // Byte positions within a packet
  localparam int POS_HDR_LAST = 2;
  localparam int POS_RSVD     = 3;
  localparam int POS_ID       = 4;
  localparam int POS_LEN      = 5;
  localparam int POS_ERR      = 8;
  localparam int POS_PARAM    = 9;

  // Length covers instruction, error and CRC bytes on top of the parameters
  localparam int LEN_BIAS = 4;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_HEADER = 3'd1,
    ST_ID     = 3'd2,
    ST_CRC    = 3'd3,
    ST_LENGTH = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_RECV,
    CS_PARAM,
    CS_STATUS
  } ctrl_state_t;

  // What the current byte does to the packet
  typedef enum logic [1:0] {
    OC_NONE,
    OC_FINISH,
    OC_PASS
  } outcome_t;

  // Source of the next result word
  typedef enum logic [1:0] {
    LD_NONE,
    LD_BYTE,
    LD_PARAM,
    LD_OK
  } load_t;

  typedef struct packed {
    logic  take;
    load_t load;
    logic  idx_clr;
    logic  idx_inc;
  } dp_cmd_t;

  typedef struct packed {
    outcome_t outcome;
    logic     n_zero;
    logic     last_param;
  } dp_stat_t;

  // CRC-16, MSB first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sspc_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Received byte channel
interface sspc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sspc_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Result item channel
interface sspc_out_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [3:0] param_index;
  logic [7:0] param_value;
  logic [2:0] status_code;
  logic [7:0] packet_id;
  logic [7:0] device_error;
  logic [4:0] param_count;
  logic       last_item;

  modport source (
    output valid, output item_kind, output param_index, output param_value,
    output status_code, output packet_id, output device_error, output param_count,
    output last_item, input ready
  );
  modport sink (
    input valid, input item_kind, input param_index, input param_value,
    input status_code, input packet_id, input device_error, input param_count,
    input last_item, output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/sspc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, registered read
module sspc_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/sspc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sspc_ctrl import sspc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     frame_start,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  ctrl_state_t state, state_next;
  logic        out_valid_next;
  logic        out_free;

  // State and result-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CS_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next  = state;
    cmd.take    = 1'b0;
    cmd.load    = LD_NONE;
    cmd.idx_clr = 1'b0;
    cmd.idx_inc = 1'b0;
    in_ready    = 1'b0;
    out_free    = !out_valid || out_ready;

    unique case (state)
      CS_IDLE, CS_RECV: begin
        in_ready = out_free;
        // bytes outside a packet are dropped
        if (in_valid && out_free && (frame_start || state == CS_RECV)) begin
          cmd.take   = 1'b1;
          state_next = CS_RECV;
          unique case (stat.outcome)
            OC_NONE: ;
            OC_FINISH: begin
              cmd.load   = LD_BYTE;
              state_next = CS_IDLE;
            end
            OC_PASS: begin
              if (stat.n_zero) begin
                cmd.load   = LD_BYTE;
                state_next = CS_IDLE;
              end else begin
                cmd.idx_clr = 1'b1;
                state_next  = CS_PARAM;
              end
            end
            default: ;
          endcase
        end
      end
      CS_PARAM: begin
        if (out_free) begin
          cmd.load = LD_PARAM;
          if (stat.last_param) begin
            state_next = CS_STATUS;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      CS_STATUS: begin
        if (out_free) begin
          cmd.load   = LD_OK;
          state_next = CS_IDLE;
        end
      end
    endcase

    out_valid_next = (cmd.load != LD_NONE) || (out_valid && !out_ready);
  end

endmodule

`default_nettype wire

// ===== rtl/core/sspc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sspc_dp import sspc_pkg::*; #(
  parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic [7:0] rx_byte,
  input  wire logic       frame_start,
  input  wire dp_cmd_t    cmd,
  output dp_stat_t        stat,
  output logic            item_kind,
  output logic [3:0]      param_index,
  output logic [7:0]      param_value,
  output logic [2:0]      status_code,
  output logic [7:0]      packet_id,
  output logic [7:0]      device_error,
  output logic [4:0]      param_count,
  output logic            last_item
);

  localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int CW = $clog2(MAX_PARAMS + 1);
  localparam int PW = $clog2(MAX_PARAMS + POS_PARAM + 2);
  localparam logic [7:0] LEN_MAX = 8'(LEN_BIAS + MAX_PARAMS);

  // Packet registers
  logic [7:0]    expected_id;
  logic [PW-1:0] byte_position;
  logic [15:0]   crc_acc;
  logic [7:0]    length_low;
  logic [7:0]    received_id;
  logic [7:0]    error_byte;
  logic [7:0]    crc_low_rx;
  logic [CW-1:0] idx;

  // Current view, restart applied
  logic [PW-1:0] p_cur;
  logic [15:0]   crc_cur;
  logic [7:0]    len_cur, id_cur, err_cur, crcl_cur;
  logic [CW-1:0] n_cur, n_new, n_reg;
  logic [PW-1:0] param_end;
  logic [15:0]   crc_upd;

  logic [15:0]   crc_new;
  logic [7:0]    len_new, id_new, err_new, crcl_new;
  outcome_t      outcome;
  status_t       code;
  logic          st_we;

  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // Expected ID register
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= ID_RST_VAL;
    end else if (cfg_wr_en) begin
      expected_id <= cfg_wr_data;
    end
  end

  // Byte decode
  always_comb begin
    p_cur    = frame_start ? '0 : byte_position;
    crc_cur  = frame_start ? '0 : crc_acc;
    len_cur  = frame_start ? '0 : length_low;
    id_cur   = frame_start ? '0 : received_id;
    err_cur  = frame_start ? '0 : error_byte;
    crcl_cur = frame_start ? '0 : crc_low_rx;

    // stored length is either in range or zero
    n_cur     = (len_cur >= 8'(LEN_BIAS)) ? CW'(len_cur - 8'(LEN_BIAS)) : '0;
    param_end = PW'(POS_PARAM) + PW'(n_cur);
    crc_upd   = crc16_byte(crc_cur, rx_byte);

    crc_new  = crc_cur;
    len_new  = len_cur;
    id_new   = id_cur;
    err_new  = err_cur;
    crcl_new = crcl_cur;
    outcome  = OC_NONE;
    code     = ST_OK;
    st_we    = 1'b0;

    priority if (p_cur <= PW'(POS_HDR_LAST)) begin
      crc_new = crc_upd;
      if (rx_byte != ((p_cur == PW'(POS_HDR_LAST)) ? HDR_LAST : HDR_SYNC)) begin
        outcome = OC_FINISH;
        code    = ST_HEADER;
      end
    end else if (p_cur == PW'(POS_RSVD)) begin
      crc_new = crc_upd;
    end else if (p_cur == PW'(POS_ID)) begin
      crc_new = crc_upd;
      id_new  = rx_byte;
      if (rx_byte != expected_id) begin
        outcome = OC_FINISH;
        code    = ST_ID;
      end
    end else if (p_cur == PW'(POS_LEN)) begin
      crc_new = crc_upd;
      if (rx_byte < 8'(LEN_BIAS) || rx_byte > LEN_MAX) begin
        len_new = '0;
        outcome = OC_FINISH;
        code    = ST_LENGTH;
      end else begin
        len_new = rx_byte;
      end
    end else if (p_cur < PW'(POS_PARAM)) begin
      crc_new = crc_upd;
      if (p_cur == PW'(POS_ERR)) begin
        err_new = rx_byte;
      end
    end else if (p_cur < param_end) begin
      crc_new = crc_upd;
      st_we   = 1'b1;
    end else if (p_cur == param_end) begin
      crcl_new = rx_byte;
    end else begin
      // CRC high byte decides the packet
      if (crcl_cur == crc_cur[7:0] && rx_byte == crc_cur[15:8]) begin
        outcome = OC_PASS;
      end else begin
        outcome = OC_FINISH;
        code    = ST_CRC;
      end
    end

    n_new = (len_new >= 8'(LEN_BIAS)) ? CW'(len_new - 8'(LEN_BIAS)) : '0;
    n_reg = (length_low >= 8'(LEN_BIAS)) ? CW'(length_low - 8'(LEN_BIAS)) : '0;

    stat.outcome    = outcome;
    stat.n_zero     = (n_new == '0);
    stat.last_param = ((idx + CW'(1)) == n_reg);

    // read address runs one ahead when the index advances
    if (cmd.idx_clr) begin
      rd_addr = '0;
    end else if (cmd.idx_inc) begin
      rd_addr = AW'(idx + CW'(1));
    end else begin
      rd_addr = AW'(idx);
    end
  end

  // Packet state update
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      crc_acc       <= '0;
      length_low    <= '0;
      received_id   <= '0;
      error_byte    <= '0;
      crc_low_rx    <= '0;
      idx           <= '0;
    end else begin
      if (cmd.take) begin
        byte_position <= p_cur + PW'(1);
        crc_acc       <= crc_new;
        length_low    <= len_new;
        received_id   <= id_new;
        error_byte    <= err_new;
        crc_low_rx    <= crcl_new;
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + CW'(1);
      end
    end
  end

  // Parameter store
  sspc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PARAMS)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.take && st_we),
    .wr_addr (AW'(p_cur - PW'(POS_PARAM))),
    .wr_data (rx_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result word register
  always_ff @(posedge clk) begin
    unique case (cmd.load)
      LD_NONE: ;
      LD_BYTE: begin
        item_kind    <= 1'b1;
        param_index  <= '0;
        param_value  <= '0;
        status_code  <= code;
        packet_id    <= id_new;
        device_error <= err_new;
        param_count  <= 5'(n_new);
        last_item    <= 1'b1;
      end
      LD_PARAM: begin
        item_kind    <= 1'b0;
        param_index  <= 4'(idx);
        param_value  <= rd_data;
        status_code  <= ST_OK;
        packet_id    <= received_id;
        device_error <= error_byte;
        param_count  <= 5'(n_reg);
        last_item    <= 1'b0;
      end
      LD_OK: begin
        item_kind    <= 1'b1;
        param_index  <= '0;
        param_value  <= '0;
        status_code  <= ST_OK;
        packet_id    <= received_id;
        device_error <= error_byte;
        param_count  <= 5'(n_reg);
        last_item    <= 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/servo_status_packet_checker.sv =====
// A byte's status word is registered and is on the result port the cycle after the byte is taken.
// Throughput: one byte per cycle while the result register is free; a good CRC with N > 0
// parameters sends N parameter words then the ok word, one per free cycle, input held off.
// Rate set by the single result register and the one read port of the parameter RAM.
// Reset (rst, synchronous): parser idle, packet registers zero, expected_id = 1;
// the parameter RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module servo_status_packet_checker import sspc_pkg::*; #(
  parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  sspc_in_if.sink         rx,
  sspc_out_if.source      res
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  sspc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (rx.valid),
    .frame_start (rx.frame_start),
    .in_ready    (rx.ready),
    .out_valid   (res.valid),
    .out_ready   (res.ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  // Parser, CRC and parameter store
  sspc_dp #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .rx_byte      (rx.rx_byte),
    .frame_start  (rx.frame_start),
    .cmd          (cmd),
    .stat         (stat),
    .item_kind    (res.item_kind),
    .param_index  (res.param_index),
    .param_value  (res.param_value),
    .status_code  (res.status_code),
    .packet_id    (res.packet_id),
    .device_error (res.device_error),
    .param_count  (res.param_count),
    .last_item    (res.last_item)
  );

endmodule

`default_nettype wire

// ===== sim/servo_status_packet_checker_tb.sv =====
`timescale 1ns / 1ps

module servo_status_packet_checker_tb;
  import sspc_pkg::*;

  localparam int N_PARAMS   = MAX_PARAMS_DEF;
  localparam int CYCLE_CAP  = 200000;
  localparam int GAP_PCT    = 11;
  localparam int HOLD_LEN   = 80;
  localparam int PHASE_BYTES = 80;
  localparam int DIR_N      = 23;

  // One result word as it leaves the block
  typedef struct packed {
    logic       kind;
    logic [3:0] idx;
    logic [7:0] val;
    status_t    status;
    logic [7:0] id;
    logic [7:0] err;
    logic [4:0] count;
    logic       last;
  } res_word_t;

  // Directed row: byte, frame start, and a hand-written result where one is obvious
  typedef struct packed {
    logic [7:0] b;
    logic       fs;
    logic       typed;
    res_word_t  want;
  } dir_row_t;

  localparam dir_row_t DIRECTED [DIR_N] = '{
    // stray byte while idle, ignored
    '{8'h55, 1'b0, 1'b0, '0},
    // bad third header byte
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, '{1'b1, 4'd0, 8'h00, ST_HEADER, 8'h00, 8'h00, 5'd0, 1'b1}},
    // wrong ID against the reset value
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFD, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b1, '{1'b1, 4'd0, 8'h00, ST_ID, 8'h02, 8'h00, 5'd0, 1'b1}},
    // length just above range
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFD, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h15, 1'b0, 1'b1, '{1'b1, 4'd0, 8'h00, ST_LENGTH, 8'h01, 8'h00, 5'd0, 1'b1}},
    // restart mid-header, then length just below range
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFD, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h03, 1'b0, 1'b1, '{1'b1, 4'd0, 8'h00, ST_LENGTH, 8'h01, 8'h00, 5'd0, 1'b1}}
  };

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  sspc_in_if  rx_ch ();
  sspc_out_if res_ch ();

  servo_status_packet_checker u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .rx         (rx_ch),
    .res        (res_ch)
  );

  // Shared flags between sender, receiver and checker
  res_word_t   expected_words [$];
  logic [8:0]  pkt_q [$];
  int          fail_count;
  int          taken_bytes;
  int          cycles;
  bit          no_gaps;
  bit          hold_req;

  // Parser copy
  logic [7:0]  cfg_id;
  bit          pk_busy;
  int          pk_pos;
  logic [15:0] pk_crc;
  logic [7:0]  pk_len;
  logic [7:0]  pk_id;
  logic [7:0]  pk_err;
  logic [7:0]  pk_crc_lo;
  logic [7:0]  pk_params [N_PARAMS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // CRC-16, poly 0x8005, MSB first
  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    repeat (8) r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    return r;
  endfunction

  function automatic int param_total();
    if (pk_len >= LEN_BIAS && pk_len <= LEN_BIAS + N_PARAMS) return pk_len - LEN_BIAS;
    return 0;
  endfunction

  function automatic void push_word(input logic kind, input logic [3:0] idx,
                                    input logic [7:0] val, input status_t st,
                                    input logic last);
    res_word_t w;
    w.kind   = kind;
    w.idx    = idx;
    w.val    = val;
    w.status = st;
    w.id     = pk_id;
    w.err    = pk_err;
    w.count  = 5'(param_total());
    w.last   = last;
    expected_words.push_back(w);
  endfunction

  function automatic void close_packet(input status_t st);
    push_word(1'b1, 4'd0, 8'h00, st, 1'b1);
    pk_busy = 1'b0;
  endfunction

  // Step the parser copy by one taken byte; returns 1 if the byte was not ignored
  function automatic bit parse_byte(input logic [7:0] b, input logic fs);
    int p;
    int n;
    if (fs) begin
      pk_pos    = 0;
      pk_crc    = '0;
      pk_len    = '0;
      pk_id     = '0;
      pk_err    = '0;
      pk_crc_lo = '0;
      pk_busy   = 1'b1;
    end
    if (!pk_busy) return 1'b0;
    p = pk_pos;
    pk_pos++;
    n = param_total();
    if (p <= POS_HDR_LAST) begin
      pk_crc = crc_next(pk_crc, b);
      if (b != ((p == POS_HDR_LAST) ? HDR_LAST : HDR_SYNC)) close_packet(ST_HEADER);
    end else if (p == POS_ID) begin
      pk_crc = crc_next(pk_crc, b);
      pk_id  = b;
      if (b != cfg_id) close_packet(ST_ID);
    end else if (p == POS_LEN) begin
      pk_crc = crc_next(pk_crc, b);
      pk_len = b;
      if (b < LEN_BIAS || b > LEN_BIAS + N_PARAMS) begin
        pk_len = '0;
        close_packet(ST_LENGTH);
      end
    end else if (p == POS_ERR) begin
      pk_crc = crc_next(pk_crc, b);
      pk_err = b;
    end else if (p < POS_PARAM) begin
      pk_crc = crc_next(pk_crc, b);
    end else if (p < POS_PARAM + n) begin
      pk_crc = crc_next(pk_crc, b);
      pk_params[p - POS_PARAM] = b;
    end else if (p == POS_PARAM + n) begin
      pk_crc_lo = b;
    end else if ({b, pk_crc_lo} == pk_crc) begin
      // good CRC: every parameter word, then the ok word
      for (int i = 0; i < n; i++) push_word(1'b0, 4'(i), pk_params[i], ST_OK, 1'b0);
      close_packet(ST_OK);
    end else begin
      close_packet(ST_CRC);
    end
    return 1'b1;
  endfunction

  // Well-formed packet with random content into pkt_q as {frame_start, byte}
  function automatic void build_packet(input logic [7:0] id, input int np);
    logic [15:0] c;
    pkt_q.delete();
    pkt_q.push_back({1'b1, HDR_SYNC});
    pkt_q.push_back({1'b0, HDR_SYNC});
    pkt_q.push_back({1'b0, HDR_LAST});
    pkt_q.push_back({1'b0, 8'($urandom_range(255))});
    pkt_q.push_back({1'b0, id});
    pkt_q.push_back({1'b0, 8'(np + LEN_BIAS)});
    pkt_q.push_back({1'b0, 8'($urandom_range(255))});
    pkt_q.push_back({1'b0, 8'($urandom_range(255))});
    pkt_q.push_back({1'b0, 8'($urandom_range(255))});
    for (int i = 0; i < np; i++) pkt_q.push_back({1'b0, 8'($urandom_range(255))});
    c = '0;
    foreach (pkt_q[i]) c = crc_next(c, pkt_q[i][7:0]);
    pkt_q.push_back({1'b0, c[7:0]});
    pkt_q.push_back({1'b0, c[15:8]});
  endfunction

  // Offer one word and wait for it to be taken; valid stays up unless a gap follows
  task automatic send_word(input logic [7:0] b, input logic fs);
    while (!no_gaps && $urandom_range(99) < GAP_PCT) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid       <= 1'b1;
    rx_ch.rx_byte     <= b;
    rx_ch.frame_start <= fs;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
  endtask

  task automatic send_packet();
    foreach (pkt_q[i]) begin
      send_word(pkt_q[i][7:0], pkt_q[i][8]);
      if (parse_byte(pkt_q[i][7:0], pkt_q[i][8])) taken_bytes++;
    end
  endtask

  // One random packet: mostly good ones, the rest broken or noise
  task automatic random_packet();
    int sel;
    int np;
    int cut;
    sel = $urandom_range(99);
    case ($urandom_range(4))
      0:       np = 0;
      1:       np = N_PARAMS;
      default: np = $urandom_range(N_PARAMS);
    endcase
    build_packet(cfg_id, np);
    if (sel < 60) begin
    end else if (sel < 70) begin
      cut = pkt_q.size() - 1 - $urandom_range(1);
      pkt_q[cut][7:0] = pkt_q[cut][7:0] ^ 8'($urandom_range(255, 1));
    end else if (sel < 75) begin
      cut = $urandom_range(POS_HDR_LAST);
      pkt_q[cut][7:0] = pkt_q[cut][7:0] ^ 8'($urandom_range(255, 1));
    end else if (sel < 80) begin
      pkt_q[POS_ID][7:0] = pkt_q[POS_ID][7:0] ^ 8'($urandom_range(255, 1));
    end else if (sel < 86) begin
      pkt_q[POS_LEN][7:0] = $urandom_range(1) ? 8'($urandom_range(LEN_BIAS - 1))
                          : 8'($urandom_range(255, LEN_BIAS + N_PARAMS + 1));
    end else if (sel < 93) begin
      // abandoned part-way; the next packet's frame start cuts it off
      cut = $urandom_range(pkt_q.size() - 1, 1);
      while (pkt_q.size() > cut) void'(pkt_q.pop_back());
    end else begin
      pkt_q.delete();
      repeat ($urandom_range(4, 1))
        pkt_q.push_back({1'($urandom_range(9) == 0), 8'($urandom_range(255))});
    end
    send_packet();
  endtask

  // Register write with the parser idle and nothing in flight
  task automatic write_expected_id(input logic [7:0] v);
    rx_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_id = v;
  endtask

  task automatic run_phase();
    int goal;
    goal = taken_bytes + PHASE_BYTES;
    while (taken_bytes < goal) random_packet();
    // finish on a clean packet so the parser is idle for the next write
    build_packet(cfg_id, $urandom_range(N_PARAMS));
    send_packet();
  endtask

  // Receiver: random back-pressure, one long hold-off on request
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        for (int k = 0; k < HOLD_LEN; k++) @(posedge clk);
        hold_req = 1'b0;
      end
      res_ch.ready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
    end
  end

  // Result checker
  task automatic check_word();
    res_word_t w;
    res_word_t got;
    got.kind   = res_ch.item_kind;
    got.idx    = res_ch.param_index;
    got.val    = res_ch.param_value;
    got.status = status_t'(res_ch.status_code);
    got.id     = res_ch.packet_id;
    got.err    = res_ch.device_error;
    got.count  = res_ch.param_count;
    got.last   = res_ch.last_item;
    if (expected_words.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected word: kind=%0d idx=%0d val=%02h st=%0d id=%02h err=%02h n=%0d last=%0d",
                 got.kind, got.idx, got.val, got.status, got.id, got.err, got.count, got.last);
    end else begin
      w = expected_words.pop_front();
      if (got.kind !== w.kind || got.idx !== w.idx || got.val !== w.val ||
          got.status !== w.status || got.id !== w.id || got.err !== w.err ||
          got.count !== w.count || got.last !== w.last) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("mismatch exp: kind=%0d idx=%0d val=%02h st=%0d id=%02h err=%02h n=%0d last=%0d",
                   w.kind, w.idx, w.val, w.status, w.id, w.err, w.count, w.last);
          $display("         got: kind=%0d idx=%0d val=%02h st=%0d id=%02h err=%02h n=%0d last=%0d",
                   got.kind, got.idx, got.val, got.status, got.id, got.err, got.count,
                   got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) check_word();
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("servo_status_packet_checker test failed");
      $finish;
    end
  end

  // Main sequence
  initial begin
    int n0;
    rst               <= 1'b1;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= 8'h00;
    rx_ch.valid       <= 1'b0;
    rx_ch.rx_byte     <= 8'h00;
    rx_ch.frame_start <= 1'b0;
    cycles      = 0;
    fail_count  = 0;
    taken_bytes = 0;
    no_gaps     = 1'b0;
    hold_req    = 1'b0;
    cfg_id      = ID_RST_VAL;
    pk_busy     = 1'b0;
    pk_pos      = 0;
    pk_crc      = '0;
    pk_len      = '0;
    pk_id       = '0;
    pk_err      = '0;
    pk_crc_lo   = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table; hand-written words replace the parser copy's
    for (int i = 0; i < DIR_N; i++) begin
      send_word(DIRECTED[i].b, DIRECTED[i].fs);
      n0 = expected_words.size();
      if (parse_byte(DIRECTED[i].b, DIRECTED[i].fs)) taken_bytes++;
      if (DIRECTED[i].typed) begin
        while (expected_words.size() > n0) void'(expected_words.pop_back());
        expected_words.push_back(DIRECTED[i].want);
      end
    end

    // random phases over several ID settings
    run_phase();
    write_expected_id(8'h00);
    hold_req = 1'b1;
    run_phase();
    write_expected_id(8'hFF);
    no_gaps = 1'b1;
    run_phase();
    no_gaps = 1'b0;
    write_expected_id(8'($urandom_range(254, 2)));
    run_phase();

    rx_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("servo_status_packet_checker test passed");
    end else begin
      $display("servo_status_packet_checker test failed");
    end
    $finish;
  end

endmodule
